/* sv/cdsd_pkg.sv */
package cdsd_pkg;

    localparam int NUM_SUITS_DEF  = 4;
    localparam int NUM_VALUES_DEF = 13;

    localparam int VALUE_W    = 4;
    localparam int SUIT_OUT_W = 2;
    localparam int LEFT_OUT_W = 6;
    localparam int SEED_W     = 32;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;
    localparam int MOD_STEP   = 4;

    localparam logic [SEED_W-1:0]  SEED_RESET   = 32'd1;
    localparam logic [PADDR_W-1:0] REG_RNG_SEED = PADDR_W'(0);

    typedef enum logic [2:0] {
        ST_FILL,
        ST_RNG,
        ST_MOD,
        ST_RD,
        ST_WR_J,
        ST_WR_I,
        ST_IDLE,
        ST_DRAW
    } state_t;

    function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] x);
        logic [SEED_W-1:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

/* sv/card_deck_shuffle_dealer.sv */
// Draw path: an accepted draw reads the store into rd_a_reg, then the DRAW state loads the
// result register once the output is free; no new draw is accepted until that load. A draw
// that empties the deck starts a refill and reshuffle, paced by the single-write-port store
// sweep and the shared 4-bit-per-cycle remainder unit. in_ready is low meanwhile.
// Reset: asynchronous active low; after release the deck is filled and shuffled with seed 1
// before the first draw is accepted.
module card_deck_shuffle_dealer #(
    parameter int NUM_SUITS  = cdsd_pkg::NUM_SUITS_DEF,
    parameter int NUM_VALUES = cdsd_pkg::NUM_VALUES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cdsd_pkg::PADDR_W-1:0]     paddr,
    input  logic [cdsd_pkg::PDATA_W-1:0]     pwdata,
    output logic [cdsd_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             draw_request,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cdsd_pkg::SUIT_OUT_W-1:0]  card_suit,
    output logic [cdsd_pkg::VALUE_W-1:0]     card_value,
    output logic [cdsd_pkg::LEFT_OUT_W-1:0]  cards_left,
    output logic                             reshuffled
);
    import cdsd_pkg::*;

    localparam int DECK_SIZE = NUM_SUITS * NUM_VALUES;
    localparam int IDX_W     = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
    localparam int CNT_W     = $clog2(DECK_SIZE + 1);
    localparam int SUIT_W    = (NUM_SUITS > 1) ? $clog2(NUM_SUITS) : 1;
    localparam int CARD_W    = SUIT_W + VALUE_W;
    localparam int MOD_CYC   = SEED_W / MOD_STEP;
    localparam int MCNT_W    = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

    localparam logic [IDX_W-1:0]   DECK_LAST = IDX_W'(DECK_SIZE - 1);
    localparam logic [CNT_W-1:0]   DECK_FULL = CNT_W'(DECK_SIZE);
    localparam logic [VALUE_W-1:0] VAL_LAST  = VALUE_W'(NUM_VALUES - 1);
    localparam logic [MCNT_W-1:0]  MCNT_LAST = MCNT_W'(MOD_CYC - 1);

    state_t state_reg, state_next;

    logic [SEED_W-1:0]     seed_reg;
    logic [SEED_W-1:0]     seed_eff;
    logic [SEED_W-1:0]     rng_reg, rng_next;
    logic [CNT_W-1:0]      top_reg, top_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      fill_addr_reg, fill_addr_next;
    logic [SUIT_W-1:0]     fill_suit_reg, fill_suit_next;
    logic [VALUE_W-1:0]    fill_val_reg, fill_val_next;
    logic [SEED_W-1:0]     div_reg, div_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [MCNT_W-1:0]     mcnt_reg, mcnt_next;
    logic [CNT_W-1:0]      divisor;

    logic                  out_valid_reg, out_valid_next;
    logic [SUIT_OUT_W-1:0] out_suit_reg, out_suit_next;
    logic [VALUE_W-1:0]    out_value_reg, out_value_next;
    logic [LEFT_OUT_W-1:0] out_left_reg, out_left_next;
    logic                  out_flag_reg, out_flag_next;

    logic [CARD_W-1:0]     deck_mem [DECK_SIZE];
    logic [CARD_W-1:0]     rd_a_reg, rd_b_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [CARD_W-1:0]     wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr_a;
    logic [IDX_W-1:0]      rd_addr_b;
    logic                  out_load;
    logic                  draw_take;
    logic [CNT_W-1:0]      top_dec;

    logic [SUIT_W+SUIT_OUT_W-1:0] suit_ext;
    logic [CNT_W+LEFT_OUT_W-1:0]  left_ext;

    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_RNG_SEED) ? seed_reg : '0;
    assign seed_eff = (seed_reg == '0) ? SEED_RESET : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            seed_reg <= pwdata;
        end
    end

    assign divisor   = CNT_W'(idx_reg) + CNT_W'(1);
    assign top_dec   = top_reg - CNT_W'(1);
    assign draw_take = in_valid && in_ready && draw_request;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (fill_addr_reg == DECK_LAST)
                begin
                    state_next = (DECK_LAST == '0) ? ST_IDLE : ST_RNG;
                end
            end
            ST_RNG:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (mcnt_reg == MCNT_LAST)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR_J;
            end
            ST_WR_J:
            begin
                state_next = ST_WR_I;
            end
            ST_WR_I:
            begin
                state_next = (idx_reg == IDX_W'(1)) ? ST_IDLE : ST_RNG;
            end
            ST_IDLE:
            begin
                if (draw_take)
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = (top_reg == '0) ? ST_FILL : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        rd_en     = (state_reg == ST_IDLE) || (state_reg == ST_RD);
        rd_addr_a = (state_reg == ST_IDLE) ? top_dec[IDX_W-1:0] : rem_reg[IDX_W-1:0];
        rd_addr_b = idx_reg;
        out_load  = (state_reg == ST_DRAW) && (!out_valid_reg || out_ready);
        mem_we    = 1'b0;
        wr_addr   = idx_reg;
        wr_data   = rd_a_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                mem_we  = 1'b1;
                wr_addr = fill_addr_reg;
                wr_data = {fill_suit_reg, fill_val_reg};
            end
            ST_WR_J:
            begin
                mem_we  = 1'b1;
                wr_addr = rem_reg[IDX_W-1:0];
                wr_data = rd_b_reg;
            end
            ST_WR_I:
            begin
                mem_we  = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_a_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        logic [CNT_W:0]   t;
        logic [CNT_W-1:0] rem_v;

        rng_next       = rng_reg;
        top_next       = top_reg;
        idx_next       = idx_reg;
        fill_addr_next = fill_addr_reg;
        fill_suit_next = fill_suit_reg;
        fill_val_next  = fill_val_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        mcnt_next      = mcnt_reg;
        t              = '0;
        rem_v          = rem_reg;

        unique case (state_reg)
            ST_FILL:
            begin
                if (fill_addr_reg == DECK_LAST)
                begin
                    fill_addr_next = '0;
                    fill_suit_next = '0;
                    fill_val_next  = '0;
                    idx_next       = DECK_LAST;
                    top_next       = DECK_FULL;
                end
                else
                begin
                    fill_addr_next = fill_addr_reg + IDX_W'(1);
                    if (fill_val_reg == VAL_LAST)
                    begin
                        fill_val_next  = '0;
                        fill_suit_next = fill_suit_reg + SUIT_W'(1);
                    end
                    else
                    begin
                        fill_val_next = fill_val_reg + VALUE_W'(1);
                    end
                end
            end
            ST_RNG:
            begin
                rng_next  = xorshift32(rng_reg);
                div_next  = xorshift32(rng_reg);
                rem_next  = '0;
                mcnt_next = '0;
            end
            ST_MOD:
            begin
                for (int k = 0; k < MOD_STEP; k++)
                begin
                    t = {rem_v, div_reg[SEED_W-1-k]};
                    if (t >= {1'b0, divisor})
                    begin
                        t = t - {1'b0, divisor};
                    end
                    rem_v = t[CNT_W-1:0];
                end
                rem_next  = rem_v;
                div_next  = div_reg << MOD_STEP;
                mcnt_next = mcnt_reg + MCNT_W'(1);
            end
            ST_WR_I:
            begin
                idx_next = idx_reg - IDX_W'(1);
            end
            ST_IDLE:
            begin
                if (draw_take)
                begin
                    top_next = top_dec;
                    if (top_reg == CNT_W'(1))
                    begin
                        rng_next = seed_eff;
                    end
                end
            end
            default:
            begin
                rem_next = rem_reg;
            end
        endcase
    end

    // result register
    assign suit_ext = {{SUIT_OUT_W{1'b0}}, rd_a_reg[CARD_W-1:VALUE_W]};
    assign left_ext = {{LEFT_OUT_W{1'b0}}, top_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_suit_next  = out_suit_reg;
        out_value_next = out_value_reg;
        out_left_next  = out_left_reg;
        out_flag_next  = out_flag_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_suit_next  = suit_ext[SUIT_OUT_W-1:0];
            out_value_next = rd_a_reg[VALUE_W-1:0];
            out_left_next  = left_ext[LEFT_OUT_W-1:0];
            out_flag_next  = (top_reg == '0);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            rng_reg       <= SEED_RESET;
            top_reg       <= DECK_FULL;
            idx_reg       <= DECK_LAST;
            fill_addr_reg <= '0;
            fill_suit_reg <= '0;
            fill_val_reg  <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rng_reg       <= rng_next;
            top_reg       <= top_next;
            idx_reg       <= idx_next;
            fill_addr_reg <= fill_addr_next;
            fill_suit_reg <= fill_suit_next;
            fill_val_reg  <= fill_val_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        out_suit_reg  <= out_suit_next;
        out_value_reg <= out_value_next;
        out_left_reg  <= out_left_next;
        out_flag_reg  <= out_flag_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            deck_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= deck_mem[rd_addr_a];
            rd_b_reg <= deck_mem[rd_addr_b];
        end
    end

    assign out_valid  = out_valid_reg;
    assign card_suit  = out_suit_reg;
    assign card_value = out_value_reg;
    assign cards_left = out_left_reg;
    assign reshuffled = out_flag_reg;

`ifndef NO_ASSERTIONS
    a_idle_deck_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((top_reg != '0) && (top_reg <= DECK_FULL)))
        else $error("deck count out of range while idle");

    a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !mem_we)
        else $error("store written while accepting transactions");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MOD) || (state_reg == ST_RD) || (state_reg == ST_WR_J))
        |-> (rem_reg < divisor))
        else $error("remainder not below divisor");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

/* sim/tb_card_deck_shuffle_dealer.sv */
`timescale 1ns / 1ps

module tb_card_deck_shuffle_dealer;

    import cdsd_pkg::*;

    localparam int DECK_CARDS     = NUM_SUITS_DEF * NUM_VALUES_DEF;
    localparam int RESHUFFLE_WAIT = 800;
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [SUIT_OUT_W-1:0] suit;
        logic [VALUE_W-1:0]    value;
        logic [LEFT_OUT_W-1:0] left;
        logic                  flag;
    } deal_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic                  draw_request;
    logic                  out_valid;
    logic                  out_ready;
    logic [SUIT_OUT_W-1:0] card_suit;
    logic [VALUE_W-1:0]    card_value;
    logic [LEFT_OUT_W-1:0] cards_left;
    logic                  reshuffled;

    card_deck_shuffle_dealer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .draw_request (draw_request),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .card_suit    (card_suit),
        .card_value   (card_value),
        .cards_left   (cards_left),
        .reshuffled   (reshuffled)
    );

    logic [5:0]  deck [DECK_CARDS];
    int unsigned deck_top;
    logic [31:0] seed_reg;

    bit    draw_pending [$];
    deal_t dealt_q [$];

    logic draw_acc    = 1'b0;
    logic rx_hold     = 1'b0;
    bit   pressure_go = 1'b0;
    int   send_pct    = 0;
    int   stall_pct   = 0;
    int   mismatches  = 0;
    int   cycle_count = 0;

    function void deck_rebuild();
        logic [31:0] x;
        logic [5:0]  t;
        int unsigned i;
        int unsigned j;
        x = (seed_reg != 32'd0) ? seed_reg : 32'd1;
        for (int s = 0; s < NUM_SUITS_DEF; s++)
            for (int v = 0; v < NUM_VALUES_DEF; v++)
                deck[s * NUM_VALUES_DEF + v] = {s[1:0], v[3:0]};
        for (i = DECK_CARDS - 1; i > 0; i--)
        begin
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
            j = x % (i + 1);
            t = deck[j];
            deck[j] = deck[i];
            deck[i] = t;
        end
        deck_top = DECK_CARDS;
    endfunction

    function void deal_card();
        deal_t     d;
        logic [5:0] c;
        if (deck_top == 0 || deck_top > DECK_CARDS)
            deck_rebuild();
        deck_top--;
        c       = deck[deck_top];
        d.suit  = c[5:4];
        d.value = c[3:0];
        d.left  = deck_top[5:0];
        d.flag  = 1'b0;
        if (deck_top == 0)
        begin
            deck_rebuild();
            d.flag = 1'b1;
        end
        dealt_q.insert(dealt_q.size(), d);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || draw_acc))
        begin
            if (draw_pending.size() != 0 && $urandom_range(99) >= send_pct)
            begin
                in_valid     <= 1'b1;
                draw_request <= draw_pending.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        out_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    // long receiver hold-off to back up the block
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        deal_t got;
        deal_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        draw_acc <= in_valid && in_ready;
        if (out_valid && out_ready)
        begin
            got = '{card_suit, card_value, cards_left, reshuffled};
            if (dealt_q.size() == 0)
            begin
                $error("unexpected transaction: suit %0d value %0d left %0d flag %0d",
                       got.suit, got.value, got.left, got.flag);
                mismatches++;
            end
            else
            begin
                want = dealt_q.pop_front();
                if (got.suit !== want.suit)
                begin
                    $error("card_suit: expected %0d, actual %0d", want.suit, got.suit);
                    mismatches++;
                end
                if (got.value !== want.value)
                begin
                    $error("card_value: expected %0d, actual %0d", want.value, got.value);
                    mismatches++;
                end
                if (got.left !== want.left)
                begin
                    $error("cards_left: expected %0d, actual %0d", want.left, got.left);
                    mismatches++;
                end
                if (got.flag !== want.flag)
                begin
                    $error("reshuffled: expected %0d, actual %0d", want.flag, got.flag);
                    mismatches++;
                end
            end
        end
        if (in_valid && in_ready && draw_request)
            deal_card();
    end

    task automatic seed_write(input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_RNG_SEED;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        seed_reg = value;
    endtask

    task automatic settle();
        while (draw_pending.size() != 0 || in_valid || dealt_q.size() != 0)
            @(posedge clk);
        // allow a trailing reshuffle or ignored request to finish
        repeat (RESHUFFLE_WAIT) @(posedge clk);
    endtask

    task automatic queue_draws(input int count);
        for (int k = 0; k < count; k++)
            draw_pending.insert(draw_pending.size(), $urandom_range(19) != 0);
    endtask

    task automatic run_phase(input logic [31:0] seed, input int count,
                             input int send, input int stall);
        seed_write(seed);
        send_pct  = send;
        stall_pct = stall;
        queue_draws(count);
        settle();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        draw_request = 1'b0;
        out_ready    = 1'b0;
        seed_reg     = SEED_RESET;
        deck_rebuild();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (RESHUFFLE_WAIT) @(posedge clk);

        // zero seed, then a short hand with idle requests mixed in
        seed_write(32'd0);
        for (int k = 0; k < 20; k++)
            draw_pending.insert(draw_pending.size(), k % 5 != 2);
        settle();

        seed_write(32'hFFFF_FFFF);
        queue_draws(300);
        pressure_go = 1'b1;
        settle();

        run_phase($urandom_range(32'hFFFF_FFFF, 1), 300, 71, 0);
        run_phase(32'd1, 300, 0, 71);
        run_phase($urandom, 300, 8, 8);
        run_phase(32'd0, 150, 0, 0);
        run_phase(32'h8000_0000, 150, 0, 0);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
sv/cdsd_pkg.sv
sv/card_deck_shuffle_dealer.sv
sim/tb_card_deck_shuffle_dealer.sv
